>>> rtl/card_number_luhn_classifier_macros.svh
// Assertion macros used by the card number classifier top level.
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_MACROS_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

// Checks that an expression holds at every clock edge outside reset.
`define CLC_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("clc assertion failed: invariant");

// Checks that a condition implies a consequence in the same cycle.
`define CLC_ASSERT_IMPLY(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("clc assertion failed: implication");

`else

`define CLC_ASSERT_ALWAYS(label, expr)
`define CLC_ASSERT_IMPLY(label, cond, conseq)

`endif

`endif

>>> rtl/clc_pkg.sv
// Shared types, constants and helper functions for the card number classifier.
package clc_pkg;

  // Width of the binary card number.
  localparam int CARD_WIDTH = 54;
  // Number of decimal digit positions held by the converter.
  localparam int MAX_DIGITS = 17;
  localparam int BCD_WIDTH = MAX_DIGITS * 4;
  localparam int COUNT_WIDTH = 5;
  localparam int SUM_WIDTH = 8;

  // Accepted card lengths.
  localparam logic [COUNT_WIDTH-1:0] LEN_SHORT = 5'd13;
  localparam logic [COUNT_WIDTH-1:0] LEN_MID = 5'd15;
  localparam logic [COUNT_WIDTH-1:0] LEN_LONG = 5'd16;

  // Leading digit values used by the prefix rules.
  localparam logic [3:0] LEAD_THREE = 4'd3;
  localparam logic [3:0] LEAD_FOUR = 4'd4;
  localparam logic [3:0] LEAD_FIVE = 4'd5;
  localparam logic [3:0] LEAD_ONE = 4'd1;
  localparam logic [3:0] LEAD_SEVEN = 4'd7;

  // Result classification codes.
  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_ONE     = 2'd1,
    KIND_TWO     = 2'd2,
    KIND_THREE   = 2'd3
  } kind_t;

  // One beat moving down the conversion chain.
  typedef struct packed {
    logic                  vld;
    logic [CARD_WIDTH-1:0] bin;
    logic [BCD_WIDTH-1:0]  bcd;
  } stage_t;

  // Digit sum of twice a decimal digit.
  function automatic logic [3:0] luhn_double(input logic [3:0] d);
    logic [4:0] p;
    begin
      p = {d, 1'b0};
      if (p >= 5'd10) begin
        luhn_double = 4'(p - 5'd9);
      end else begin
        luhn_double = p[3:0];
      end
    end
  endfunction

  // True when a digit sum is a multiple of ten.
  function automatic logic is_mult10(input logic [SUM_WIDTH-1:0] s);
    logic hit;
    begin
      hit = 1'b0;
      for (int k = 0; k < 26; k++) begin
        if (s == SUM_WIDTH'(k * 10)) begin
          hit = 1'b1;
        end
      end
      is_mult10 = hit;
    end
  endfunction

endpackage

>>> rtl/clc_dabble_cell.sv
// One cell of the binary to BCD chain: adjusts all digits and shifts in one bit.
module clc_dabble_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  clc_pkg::stage_t cur,
  output clc_pkg::stage_t nxt
);

  clc_pkg::stage_t              stage_next;
  clc_pkg::stage_t              stage;
  logic [clc_pkg::BCD_WIDTH-1:0] adj;

  // Add three to every digit of five or more, then shift the next bit in.
  always_comb begin
    logic [3:0] dig;
    dig = 4'd0;
    for (int i = 0; i < clc_pkg::MAX_DIGITS; i++) begin
      dig = cur.bcd[i*4 +: 4];
      adj[i*4 +: 4] = (dig >= 4'd5) ? 4'(dig + 4'd3) : dig;
    end
    stage_next.vld = cur.vld;
    stage_next.bin = {cur.bin[clc_pkg::CARD_WIDTH-2:0], 1'b0};
    stage_next.bcd = {adj[clc_pkg::BCD_WIDTH-2:0], cur.bin[clc_pkg::CARD_WIDTH-1]};
  end

  // The valid bit resets; the payload moves whenever the chain advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.vld <= 1'b0;
    end else if (en) begin
      stage.vld <= stage_next.vld;
    end
    if (en) begin
      stage.bin <= stage_next.bin;
      stage.bcd <= stage_next.bcd;
    end
  end

  assign nxt = stage;

endmodule

>>> rtl/clc_grade.sv
// Digit count, Luhn sum and prefix classification over the converted digits.
module clc_grade (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  clc_pkg::stage_t                 cur,
  output logic                            result_valid,
  output logic [1:0]                      card_kind,
  output logic                            checksum_ok,
  output logic [clc_pkg::COUNT_WIDTH-1:0] digit_total
);

  logic [3:0]                      dg [clc_pkg::MAX_DIGITS];
  logic [clc_pkg::COUNT_WIDTH-1:0] count_next;
  logic [clc_pkg::SUM_WIDTH-1:0]   even_next;
  logic [clc_pkg::SUM_WIDTH-1:0]   odd_next;
  logic                            pre_one_next;
  logic                            pre_two_next;
  logic                            pre_short_next;
  logic                            pre_long_next;

  logic                            vld_a;
  logic [clc_pkg::COUNT_WIDTH-1:0] count_a;
  logic [clc_pkg::SUM_WIDTH-1:0]   even_a;
  logic [clc_pkg::SUM_WIDTH-1:0]   odd_a;
  logic                            pre_one_a;
  logic                            pre_two_a;
  logic                            pre_short_a;
  logic                            pre_long_a;

  logic [clc_pkg::SUM_WIDTH-1:0]   total;
  logic                            ok_next;
  clc_pkg::kind_t                  kind_next;

  // Split the BCD word into digits, least significant first.
  always_comb begin
    for (int i = 0; i < clc_pkg::MAX_DIGITS; i++) begin
      dg[i] = cur.bcd[i*4 +: 4];
    end
  end

  // First stage: count, two partial Luhn sums and prefix flags.
  always_comb begin
    count_next = '0;
    even_next = '0;
    odd_next = '0;
    for (int i = 0; i < clc_pkg::MAX_DIGITS; i++) begin
      if (dg[i] != 4'd0) begin
        count_next = clc_pkg::COUNT_WIDTH'(i + 1);
      end
      if ((i % 2) == 0) begin
        even_next = clc_pkg::SUM_WIDTH'(even_next + clc_pkg::SUM_WIDTH'(dg[i]));
      end else begin
        odd_next = clc_pkg::SUM_WIDTH'(odd_next
                   + clc_pkg::SUM_WIDTH'(clc_pkg::luhn_double(dg[i])));
      end
    end
    // Leading digits sit at fixed positions for each accepted length.
    pre_one_next = (dg[14] == clc_pkg::LEAD_THREE) &&
                   ((dg[13] == clc_pkg::LEAD_FOUR) || (dg[13] == clc_pkg::LEAD_SEVEN));
    pre_two_next = (dg[15] == clc_pkg::LEAD_FIVE) &&
                   (dg[14] >= clc_pkg::LEAD_ONE) && (dg[14] <= clc_pkg::LEAD_FIVE);
    pre_short_next = (dg[12] == clc_pkg::LEAD_FOUR);
    pre_long_next = (dg[15] == clc_pkg::LEAD_FOUR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (en) begin
      vld_a <= cur.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      count_a <= count_next;
      even_a <= even_next;
      odd_a <= odd_next;
      pre_one_a <= pre_one_next;
      pre_two_a <= pre_two_next;
      pre_short_a <= pre_short_next;
      pre_long_a <= pre_long_next;
    end
  end

  // Second stage: final sum, mod-10 test and classification.
  always_comb begin
    total = clc_pkg::SUM_WIDTH'(even_a + odd_a);
    ok_next = clc_pkg::is_mult10(total);
    kind_next = clc_pkg::KIND_INVALID;
    if (ok_next) begin
      if (pre_one_a && (count_a == clc_pkg::LEN_MID)) begin
        kind_next = clc_pkg::KIND_ONE;
      end else if (pre_two_a && (count_a == clc_pkg::LEN_LONG)) begin
        kind_next = clc_pkg::KIND_TWO;
      end else if ((pre_short_a && (count_a == clc_pkg::LEN_SHORT)) ||
                   (pre_long_a && (count_a == clc_pkg::LEN_LONG))) begin
        kind_next = clc_pkg::KIND_THREE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      card_kind <= kind_next;
      checksum_ok <= ok_next;
      digit_total <= count_a;
    end
  end

endmodule

>>> rtl/card_number_luhn_classifier.sv
// Throughput: one card per cycle while no result is held; the chain of 54 shift-and-adjust cells
// converts one input bit per cell, followed by two grading stages.
// The whole pipeline advances unless a result waits under stall.
// Reset is synchronous and clears only the valid bits of every stage.
// Top level of the card number classifier.
module card_number_luhn_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            card_valid,
  output logic                            card_stall,
  input  logic [clc_pkg::CARD_WIDTH-1:0]  card_value,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [1:0]                      card_kind,
  output logic                            checksum_ok,
  output logic [clc_pkg::COUNT_WIDTH-1:0] digit_total
);

`include "card_number_luhn_classifier_macros.svh"

  clc_pkg::stage_t chain [clc_pkg::CARD_WIDTH+1];
  logic            en;
  logic            kind_hit;
  logic            len_ok;
  logic            count_ok;

  // Every stage moves together unless the output beat is held.
  assign en = !(result_valid && result_stall);
  assign card_stall = !en;

  assign chain[0].vld = card_valid;
  assign chain[0].bin = card_value;
  assign chain[0].bcd = '0;

  // One cell per input bit, most significant bit first.
  for (genvar g = 0; g < clc_pkg::CARD_WIDTH; g++) begin : g_cell
    clc_dabble_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .cur (chain[g]),
      .nxt (chain[g+1])
    );
  end

  clc_grade u_grade (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cur          (chain[clc_pkg::CARD_WIDTH]),
    .result_valid (result_valid),
    .card_kind    (card_kind),
    .checksum_ok  (checksum_ok),
    .digit_total  (digit_total)
  );

  // Terms shared by the checks below.
  assign kind_hit = result_valid && (card_kind != clc_pkg::KIND_INVALID);
  assign len_ok = (digit_total == clc_pkg::LEN_SHORT) || (digit_total == clc_pkg::LEN_MID) ||
                  (digit_total == clc_pkg::LEN_LONG);
  assign count_ok = (digit_total <= clc_pkg::COUNT_WIDTH'(clc_pkg::MAX_DIGITS));

  // A held result beat must hold the input side too.
  `CLC_ASSERT_IMPLY(a_stall_back, result_valid && result_stall, card_stall)
  // A classified card always passed the Luhn check.
  `CLC_ASSERT_IMPLY(a_kind_ok, kind_hit, checksum_ok)
  // A classified card always has an accepted length.
  `CLC_ASSERT_IMPLY(a_kind_len, kind_hit, len_ok)
  // The digit count never exceeds the converter's digit positions.
  `CLC_ASSERT_IMPLY(a_count_max, result_valid, count_ok)

endmodule
